// ===== hdl/pdlk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdlk_pkg;

  localparam int unsigned COORD_FRAC_BITS_DEF = 24;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic signed [71:0] Q_MAX_W = 72'sd2147483647;
  localparam logic signed [71:0] Q_MIN_W = -72'sd2147483648;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIFT_LENGTH  = 3'd0,
    CFG_INV_GAMMA_SQ  = 3'd1,
    CFG_DP_COEFF      = 3'd2,
    CFG_KICK_STRENGTH = 3'd3,
    CFG_INV_WIDTH_SQ  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] drift_length;
    logic [24:0]        inv_gamma_sq;
    logic signed [31:0] energy_to_dp_coeff;
    logic signed [31:0] kick_strength;
    logic [39:0]        inv_width_sq;
  } pdlk_cfg_t;

  // per-particle payload that rides through the whole pipe
  typedef struct packed {
    logic               kick;
    logic               live;
    logic               last;
    logic signed [31:0] x;
    logic signed [31:0] px;
    logic signed [31:0] y;
    logic signed [31:0] py;
    logic signed [31:0] z;
    logic signed [31:0] h;
    logic signed [31:0] dg;
  } pdlk_tag_t;

  // request handed from the front to the back through the queue
  typedef struct packed {
    pdlk_tag_t   tag;
    logic [32:0] ua;
    logic        neg;
  } pdlk_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > Q_MAX_W) return Q_MAX;
    else if (v < Q_MIN_W) return Q_MIN;
    else return v[31:0];
  endfunction

  // exact product, floor shift, saturate
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input int unsigned s);
    logic signed [63:0] p;
    p = a * b;
    p = p >>> s;
    return sat32(72'(p));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pdlk_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pdlk_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] pos_x;
  logic signed [31:0] mom_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] mom_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] energy_offset;
  logic               alive;
  logic               last_in_pass;

  modport source (output valid, command, pos_x, mom_x, pos_y, mom_y, pos_z,
                  energy_offset, alive, last_in_pass, input ready);
  modport sink (input valid, command, pos_x, mom_x, pos_y, mom_y, pos_z,
                energy_offset, alive, last_in_pass, output ready);
endinterface

`default_nettype wire

// ===== hdl/pdlk_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pdlk_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_px;
  logic signed [31:0] new_y;
  logic signed [31:0] new_py;
  logic signed [31:0] new_z;
  logic               pass_done;

  modport source (output valid, new_x, new_px, new_y, new_py, new_z, pass_done,
                  input ready);
  modport sink (input valid, new_x, new_px, new_y, new_py, new_z, pass_done,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/particle_drift_and_lens_kick_core.sv =====
// Throughput: one particle per cycle while nothing stalls, set by the fully pipelined
// divider of 33 + 2*COORD_FRAC_BITS one-bit stages; front and back stall independently.
// Reset: synchronous, active low; empties the pipe and the queue and loads the
// register defaults (length 0, 1/gamma^2 1.0, coefficients 0, 1/width^2 1.0).
`timescale 1ns / 1ps
`default_nettype none

module particle_drift_and_lens_kick_core #(
  parameter int unsigned COORD_FRAC_BITS = pdlk_pkg::COORD_FRAC_BITS_DEF,
  localparam int unsigned UD_W = (COORD_FRAC_BITS > 31) ? COORD_FRAC_BITS + 2 : 33
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pdlk_in_if.sink                             in_chan,
  pdlk_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [pdlk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdlk_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pdlk_pkg::*;

  pdlk_cfg_t  cfg_r;
  logic       q_full, q_push, q_empty, q_pop;
  pdlk_item_t f_item, h_item;
  logic [UD_W-1:0] f_ud, h_ud;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drift_length       <= '0;
      cfg_r.inv_gamma_sq       <= 25'h1000000;
      cfg_r.energy_to_dp_coeff <= '0;
      cfg_r.kick_strength      <= '0;
      cfg_r.inv_width_sq       <= 40'd256;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DRIFT_LENGTH:  cfg_r.drift_length       <= cfg_wdata[31:0];
        CFG_INV_GAMMA_SQ:  cfg_r.inv_gamma_sq       <= cfg_wdata[24:0];
        CFG_DP_COEFF:      cfg_r.energy_to_dp_coeff <= cfg_wdata[31:0];
        CFG_KICK_STRENGTH: cfg_r.kick_strength      <= cfg_wdata[31:0];
        CFG_INV_WIDTH_SQ:  cfg_r.inv_width_sq       <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  pdlk_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_chan(in_chan),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (f_item),
    .q_ud   (f_ud)
  );

  pdlk_queue #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(f_item),
    .push_ud  (f_ud),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_item(h_item),
    .head_ud  (h_ud)
  );

  pdlk_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_item  (h_item),
    .q_ud    (h_ud),
    .q_pop   (q_pop),
    .out_chan(out_chan)
  );

endmodule

`default_nettype wire

// ===== hdl/pdlk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdlk_front #(
  parameter int unsigned COORD_FRAC_BITS = pdlk_pkg::COORD_FRAC_BITS_DEF,
  localparam int unsigned UD_W = (COORD_FRAC_BITS > 31) ? COORD_FRAC_BITS + 2 : 33
) (
  input  logic                   clk,
  input  logic                   rst_n,
  pdlk_in_if.sink                in_chan,
  input  pdlk_pkg::pdlk_cfg_t    cfg,
  input  logic                   q_full,
  output logic                   q_push,
  output pdlk_pkg::pdlk_item_t   q_item,
  output logic [UD_W-1:0]        q_ud
);
  import pdlk_pkg::*;

  localparam logic signed [UD_W:0] ONE_W = {{UD_W{1'b0}}, 1'b1} << COORD_FRAC_BITS;

  logic fe;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  pdlk_tag_t t1_r, t2_r, t3_r, t4_r;
  pdlk_tag_t t2_nxt, t4_nxt;
  logic signed [31:0] dp1_r, a1_r, b1_r, xx1_r, yy1_r;
  logic signed [UD_W:0] den2_r, den3_r, den4_r;
  logic signed [31:0] dq2_r;
  logic signed [33:0] ab2_r, ab3_r;
  logic [30:0] r2_2_r;
  logic signed [31:0] dg2_3_r;
  logic [63:0] plo3_r;
  logic [38:0] phi3_r;
  logic [30:0] u4_r;

  logic signed [33:0] r2_sum;
  logic signed [31:0] r2_sat;
  logic [71:0] uw_sum;
  logic signed [34:0] h_sum;
  logic signed [32:0] s33;
  logic signed [UD_W:0] den_neg;

  pdlk_item_t item5_r;
  logic [UD_W-1:0] ud5_r;

  // advance the whole front unless the tail item cannot enter the queue
  assign fe = !v5_r || !q_full;
  assign in_chan.ready = fe;
  assign q_push = v5_r && !q_full;
  assign q_item = item5_r;
  assign q_ud = ud5_r;

  always_comb begin
    r2_sum = 34'(xx1_r) + 34'(yy1_r);
    r2_sat = sat32(72'(r2_sum));
    uw_sum = 72'({phi3_r, 32'b0}) + 72'(plo3_r);
    h_sum = 35'(ab3_r) + 35'(dg2_3_r);
    s33 = 33'(cfg.kick_strength);
    den_neg = -den4_r;
    t2_nxt = t1_r;
    t2_nxt.dg = mulq(dp1_r, $signed({7'b0, cfg.inv_gamma_sq}), 24);
    t4_nxt = t3_r;
    t4_nxt.h = sat32(72'(h_sum >>> 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (fe) begin
      v1_r <= in_chan.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      // first products
      t1_r.kick <= in_chan.command;
      t1_r.live <= in_chan.alive;
      t1_r.last <= in_chan.last_in_pass;
      t1_r.x    <= in_chan.pos_x;
      t1_r.px   <= in_chan.mom_x;
      t1_r.y    <= in_chan.pos_y;
      t1_r.py   <= in_chan.mom_y;
      t1_r.z    <= in_chan.pos_z;
      t1_r.h    <= '0;
      t1_r.dg   <= '0;
      dp1_r <= mulq(in_chan.energy_offset, cfg.energy_to_dp_coeff, COORD_FRAC_BITS);
      a1_r  <= mulq(in_chan.mom_x, in_chan.mom_x, COORD_FRAC_BITS);
      b1_r  <= mulq(in_chan.mom_y, in_chan.mom_y, COORD_FRAC_BITS);
      xx1_r <= mulq(in_chan.pos_x, in_chan.pos_x, COORD_FRAC_BITS);
      yy1_r <= mulq(in_chan.pos_y, in_chan.pos_y, COORD_FRAC_BITS);

      t2_r    <= t2_nxt;
      den2_r  <= (UD_W+1)'(dp1_r) + ONE_W;
      dq2_r   <= mulq(dp1_r, dp1_r, COORD_FRAC_BITS);
      ab2_r   <= 34'(a1_r) + 34'(b1_r);
      r2_2_r  <= r2_sat[30:0];

      t3_r    <= t2_r;
      den3_r  <= den2_r;
      ab3_r   <= ab2_r;
      dg2_3_r <= mulq(dq2_r, $signed({7'b0, cfg.inv_gamma_sq}), 24);
      plo3_r  <= 64'(r2_2_r) * 64'(cfg.inv_width_sq[31:0]);
      phi3_r  <= 39'(r2_2_r) * 39'(cfg.inv_width_sq[39:32]);

      t4_r   <= t4_nxt;
      den4_r <= den3_r;
      u4_r   <= (|uw_sum[71:39]) ? 31'h7fffffff : uw_sum[38:8];

      // divider operands: drift divides 1.0 by den, kick divides strength by u + 1.0
      item5_r.tag <= t4_r;
      if (t4_r.kick) begin
        item5_r.ua  <= s33[32] ? 33'(-s33) : 33'(s33);
        item5_r.neg <= s33[32];
        ud5_r       <= UD_W'(u4_r) + UD_W'(ONE_W);
      end else begin
        item5_r.ua  <= 33'd1;
        item5_r.neg <= den4_r[UD_W];
        ud5_r       <= den4_r[UD_W] ? den_neg[UD_W-1:0] : den4_r[UD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pdlk_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdlk_queue #(
  parameter int unsigned COORD_FRAC_BITS = pdlk_pkg::COORD_FRAC_BITS_DEF,
  localparam int unsigned UD_W = (COORD_FRAC_BITS > 31) ? COORD_FRAC_BITS + 2 : 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pdlk_pkg::pdlk_item_t push_item,
  input  logic [UD_W-1:0]      push_ud,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output pdlk_pkg::pdlk_item_t head_item,
  output logic [UD_W-1:0]      head_ud
);
  import pdlk_pkg::*;

  pdlk_item_t      item_r [QUEUE_DEPTH];
  logic [UD_W-1:0] ud_r   [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head_item = item_r[rd_ptr_r];
  assign head_ud = ud_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item_r[wr_ptr_r] <= push_item;
      ud_r[wr_ptr_r]   <= push_ud;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pdlk_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per stage
module pdlk_divider #(
  parameter int unsigned COORD_FRAC_BITS = pdlk_pkg::COORD_FRAC_BITS_DEF,
  localparam int unsigned UD_W = (COORD_FRAC_BITS > 31) ? COORD_FRAC_BITS + 2 : 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  pdlk_pkg::pdlk_item_t in_item,
  input  logic [UD_W-1:0]      in_ud,
  output logic                 out_valid,
  output pdlk_pkg::pdlk_tag_t  out_tag,
  output logic signed [31:0]   out_quot
);
  import pdlk_pkg::*;

  localparam int unsigned NS = 33 + 2 * COORD_FRAC_BITS;

  logic            v_r   [NS];
  pdlk_item_t      it_r  [NS];
  logic [UD_W-1:0] ud_r  [NS];
  logic [UD_W-1:0] rem_r [NS];
  logic [31:0]     q_r   [NS];
  logic            ovf_r [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam int unsigned P = NS - 1 - i;
    logic            v_in;
    pdlk_item_t      it_in;
    logic [UD_W-1:0] ud_in, rem_in;
    logic [31:0]     q_in;
    logic            ovf_in;
    logic            kbit, dbit_drift, dbit;
    logic [UD_W:0]   rn, diff;
    logic            ge;

    if (i == 0) begin : g_head
      assign v_in   = in_valid;
      assign it_in  = in_item;
      assign ud_in  = in_ud;
      assign rem_in = '0;
      assign q_in   = '0;
      assign ovf_in = 1'b0;
    end else begin : g_body
      assign v_in   = v_r[i-1];
      assign it_in  = it_r[i-1];
      assign ud_in  = ud_r[i-1];
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign ovf_in = ovf_r[i-1];
    end

    // dividend bit: strength sits above F zero bits, 1.0 sits at bit 2F
    if (P >= COORD_FRAC_BITS && P <= COORD_FRAC_BITS + 32) begin : g_kb
      assign kbit = it_in.ua[P - COORD_FRAC_BITS];
    end else begin : g_kz
      assign kbit = 1'b0;
    end
    assign dbit_drift = (P == 2 * COORD_FRAC_BITS);
    assign dbit = it_in.tag.kick ? kbit : dbit_drift;

    assign rn = {rem_in, dbit};
    assign diff = rn - {1'b0, ud_in};
    assign ge = (rn >= {1'b0, ud_in});

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else if (en) v_r[i] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[i]  <= it_in;
        ud_r[i]  <= ud_in;
        rem_r[i] <= ge ? diff[UD_W-1:0] : rn[UD_W-1:0];
        q_r[i]   <= {q_in[30:0], ge};
        ovf_r[i] <= ovf_in | q_in[31];
      end
    end
  end

  logic sat;
  assign sat = ovf_r[NS-1] | q_r[NS-1][31];
  assign out_valid = v_r[NS-1];
  assign out_tag = it_r[NS-1].tag;

  always_comb begin
    if (it_r[NS-1].neg) out_quot = sat ? Q_MIN : -$signed(q_r[NS-1]);
    else out_quot = sat ? Q_MAX : $signed(q_r[NS-1]);
  end

endmodule

`default_nettype wire

// ===== hdl/pdlk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdlk_back #(
  parameter int unsigned COORD_FRAC_BITS = pdlk_pkg::COORD_FRAC_BITS_DEF,
  localparam int unsigned UD_W = (COORD_FRAC_BITS > 31) ? COORD_FRAC_BITS + 2 : 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdlk_pkg::pdlk_cfg_t  cfg,
  input  logic                 q_empty,
  input  pdlk_pkg::pdlk_item_t q_item,
  input  logic [UD_W-1:0]      q_ud,
  output logic                 q_pop,
  pdlk_out_if.source           out_chan
);
  import pdlk_pkg::*;

  logic be;
  logic dv;
  pdlk_tag_t dt;
  logic signed [31:0] dk;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  pdlk_tag_t t1_r, t2_r, t3_r, t4_r;
  logic signed [31:0] k1_r, tt1_r, hk1_r, dx1_r, dy1_r;
  logic signed [31:0] k2_r, tpx2_r, tpy2_r, h1_2_r, npx2_r, npy2_r;
  logic signed [31:0] nx3_r, ny3_r, h2_3_r, npx3_r, npy3_r;
  logic signed [31:0] nx4_r, ny4_r, lh4_r, npx4_r, npy4_r;
  logic signed [31:0] ox_r, opx_r, oy_r, opy_r, oz_r;
  logic               olast_r;

  // hold everything while the result register is full and not taken
  assign be = !v5_r || out_chan.ready;
  assign q_pop = be && !q_empty;

  pdlk_divider #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (be),
    .in_valid (!q_empty),
    .in_item  (q_item),
    .in_ud    (q_ud),
    .out_valid(dv),
    .out_tag  (dt),
    .out_quot (dk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (be) begin
      v1_r <= dv;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      t1_r  <= dt;
      k1_r  <= dk;
      tt1_r <= mulq(dk, cfg.drift_length, COORD_FRAC_BITS);
      hk1_r <= mulq(dt.h, dk, COORD_FRAC_BITS);
      dx1_r <= mulq(dk, dt.x, COORD_FRAC_BITS);
      dy1_r <= mulq(dk, dt.y, COORD_FRAC_BITS);

      t2_r   <= t1_r;
      k2_r   <= k1_r;
      tpx2_r <= mulq(tt1_r, t1_r.px, COORD_FRAC_BITS);
      tpy2_r <= mulq(tt1_r, t1_r.py, COORD_FRAC_BITS);
      h1_2_r <= sat32(72'(hk1_r) - 72'(t1_r.dg));
      npx2_r <= sat32(72'(t1_r.px) + 72'(dx1_r));
      npy2_r <= sat32(72'(t1_r.py) + 72'(dy1_r));

      t3_r   <= t2_r;
      nx3_r  <= sat32(72'(t2_r.x) + 72'(tpx2_r));
      ny3_r  <= sat32(72'(t2_r.y) + 72'(tpy2_r));
      h2_3_r <= mulq(h1_2_r, k2_r, COORD_FRAC_BITS);
      npx3_r <= npx2_r;
      npy3_r <= npy2_r;

      t4_r   <= t3_r;
      nx4_r  <= nx3_r;
      ny4_r  <= ny3_r;
      lh4_r  <= mulq(cfg.drift_length, h2_3_r, COORD_FRAC_BITS);
      npx4_r <= npx3_r;
      npy4_r <= npy3_r;

      olast_r <= t4_r.last;
      if (!t4_r.kick) begin
        ox_r  <= nx4_r;
        opx_r <= t4_r.px;
        oy_r  <= ny4_r;
        opy_r <= t4_r.py;
        oz_r  <= sat32(72'(t4_r.z) - 72'(lh4_r));
      end else if (t4_r.live) begin
        ox_r  <= t4_r.x;
        opx_r <= npx4_r;
        oy_r  <= t4_r.y;
        opy_r <= npy4_r;
        oz_r  <= t4_r.z;
      end else begin
        ox_r  <= t4_r.x;
        opx_r <= t4_r.px;
        oy_r  <= t4_r.y;
        opy_r <= t4_r.py;
        oz_r  <= t4_r.z;
      end
    end
  end

  assign out_chan.valid     = v5_r;
  assign out_chan.new_x     = ox_r;
  assign out_chan.new_px    = opx_r;
  assign out_chan.new_y     = oy_r;
  assign out_chan.new_py    = opy_r;
  assign out_chan.new_z     = oz_r;
  assign out_chan.pass_done = olast_r;

endmodule

`default_nettype wire

// ===== hdl/pdlk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdlk_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] new_x,
  input logic signed [31:0] new_px,
  input logic signed [31:0] new_y,
  input logic signed [31:0] new_py,
  input logic signed [31:0] new_z,
  input logic               pass_done
);
  logic [7:0] cnt_r, cnt_nxt;
  logic in_acc, out_acc;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) cnt_nxt = cnt_r + 8'd1;
    else if (out_acc && !in_acc) cnt_nxt = cnt_r - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  // no result without a request in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 8'd0)
    else $error("result without outstanding request");

  // a lone request cannot come out on the next edge
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && cnt_r == 8'd0 |=> !out_valid)
    else $error("result too early");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(new_x) && $stable(new_px) && $stable(new_y)
      && $stable(new_py) && $stable(new_z) && $stable(pass_done))
    else $error("result changed while stalled");

endmodule

bind particle_drift_and_lens_kick_core pdlk_checker u_pdlk_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_chan.valid),
  .in_ready (in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .new_x    (out_chan.new_x),
  .new_px   (out_chan.new_px),
  .new_y    (out_chan.new_y),
  .new_py   (out_chan.new_py),
  .new_z    (out_chan.new_z),
  .pass_done(out_chan.pass_done)
);

`default_nettype wire

// ===== tb/tb_particle_drift_and_lens_kick_core.sv =====
`timescale 1ns / 1ps

module tb_particle_drift_and_lens_kick_core;
  import pdlk_pkg::*;

  localparam longint ONE = 64'sd1 << 24;
  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;
  localparam int PIPE_WAIT = 120;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    bit     kick;
    int     x, px, y, py, z, de;
    bit     alive;
    bit     last;
  } particle_t;

  typedef struct {
    int x, px, y, py, z;
    bit done;
  } coords_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pdlk_in_if in_ch ();
  pdlk_out_if out_ch ();

  particle_drift_and_lens_kick_core dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_ch.sink), .out_chan(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // register shadow of the lattice settings
  longint len_q, gam_q, coeff_q, kick_q;
  longint unsigned width_q;

  coords_t expected_coords[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint sat_q(longint v);
    return v > QHI ? QHI : (v < QLO ? QLO : v);
  endfunction

  function automatic longint mul_fix(longint a, longint b, int s);
    return sat_q((a * b) >>> s);
  endfunction

  // restoring division with early clamp, truncates toward zero
  function automatic longint div_fix(longint a, longint d, int sh);
    longint unsigned ua, ud, r, q;
    bit neg;
    if (d == 0) return a >= 0 ? QHI : QLO;
    ua = a < 0 ? -a : a;
    ud = d < 0 ? -d : d;
    neg = (a < 0) != (d < 0);
    r = 0;
    q = 0;
    for (int i = 32; i >= 0; i--) begin
      r = (r << 1) | ((ua >> i) & 1);
      q = q << 1;
      if (r >= ud) begin
        r -= ud;
        q |= 1;
      end
      if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    end
    for (int j = 0; j < sh; j++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r -= ud;
        q |= 1;
      end
      if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    end
    if (neg) return q >= 64'h8000_0000 ? QLO : -longint'(q);
    return q >= 64'h8000_0000 ? QHI : longint'(q);
  endfunction

  function automatic coords_t step_particle(particle_t p);
    coords_t c;
    longint x, px, y, py, z;
    longint dp, k, t, a, b, dq, dg2, dg, h, h1, h2, r2, u, delta;
    logic [127:0] wide;
    x = p.x; px = p.px; y = p.y; py = p.py; z = p.z;
    if (!p.kick) begin
      dp = mul_fix(p.de, coeff_q, 24);
      k = div_fix(1, dp + ONE, 48);
      t = mul_fix(k, len_q, 24);
      a = mul_fix(px, px, 24);
      b = mul_fix(py, py, 24);
      dq = mul_fix(dp, dp, 24);
      dg2 = mul_fix(dq, gam_q, 24);
      dg = mul_fix(dp, gam_q, 24);
      h = sat_q((a + b + dg2) >>> 1);
      h1 = sat_q(mul_fix(h, k, 24) - dg);
      h2 = mul_fix(h1, k, 24);
      x = sat_q(x + mul_fix(t, px, 24));
      y = sat_q(y + mul_fix(t, py, 24));
      z = sat_q(z - mul_fix(len_q, h2, 24));
    end else if (p.alive) begin
      r2 = sat_q(mul_fix(x, x, 24) + mul_fix(y, y, 24));
      wide = 128'(r2) * 128'(width_q);
      wide = wide >> 8;
      u = wide > 128'(QHI) ? QHI : longint'(wide);
      delta = div_fix(kick_q, u + ONE, 24);
      px = sat_q(px + mul_fix(delta, x, 24));
      py = sat_q(py + mul_fix(delta, y, 24));
    end
    c.x = int'(x); c.px = int'(px); c.y = int'(y); c.py = int'(py); c.z = int'(z);
    c.done = p.last;
    return c;
  endfunction

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    coords_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_coords.size() == 0) begin
        $display("%0t: unexpected result x=%h", $time, out_ch.new_x);
        errors++;
      end else begin
        e = expected_coords.pop_front();
        if (out_ch.new_x !== e.x) begin
          $display("%0t: new_x exp %h got %h", $time, e.x, out_ch.new_x); errors++;
        end
        if (out_ch.new_px !== e.px) begin
          $display("%0t: new_px exp %h got %h", $time, e.px, out_ch.new_px); errors++;
        end
        if (out_ch.new_y !== e.y) begin
          $display("%0t: new_y exp %h got %h", $time, e.y, out_ch.new_y); errors++;
        end
        if (out_ch.new_py !== e.py) begin
          $display("%0t: new_py exp %h got %h", $time, e.py, out_ch.new_py); errors++;
        end
        if (out_ch.new_z !== e.z) begin
          $display("%0t: new_z exp %h got %h", $time, e.z, out_ch.new_z); errors++;
        end
        if (out_ch.pass_done !== e.done) begin
          $display("%0t: pass_done exp %b got %b", $time, e.done, out_ch.pass_done);
          errors++;
        end
      end
    end
  end

  task automatic send_particle(particle_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= p.kick;
    in_ch.pos_x <= p.x;
    in_ch.mom_x <= p.px;
    in_ch.pos_y <= p.y;
    in_ch.mom_y <= p.py;
    in_ch.pos_z <= p.z;
    in_ch.energy_offset <= p.de;
    in_ch.alive <= p.alive;
    in_ch.last_in_pass <= p.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_coords.push_back(step_particle(p));
  endtask

  // hold the request low, drain the pipe, then let it settle
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DRIFT_LENGTH:  len_q = longint'(signed'(val[31:0]));
      CFG_INV_GAMMA_SQ:  gam_q = val[24:0];
      CFG_DP_COEFF:      coeff_q = longint'(signed'(val[31:0]));
      CFG_KICK_STRENGTH: kick_q = longint'(signed'(val[31:0]));
      CFG_INV_WIDTH_SQ:  width_q = val[39:0];
      default: ;
    endcase
  endtask

  task automatic load_lattice(longint l, longint g, longint c, longint s,
                              longint unsigned w);
    drain_pipe();
    write_reg(CFG_DRIFT_LENGTH, 40'(l));
    write_reg(CFG_INV_GAMMA_SQ, 40'(g));
    write_reg(CFG_DP_COEFF, 40'(c));
    write_reg(CFG_KICK_STRENGTH, 40'(s));
    write_reg(CFG_INV_WIDTH_SQ, 40'(w));
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    p.kick = $urandom_range(1);
    p.x = rand_coord(); p.px = rand_coord(); p.y = rand_coord();
    p.py = rand_coord(); p.z = rand_coord(); p.de = rand_coord();
    p.alive = $urandom_range(7) != 0;
    p.last = $urandom_range(7) == 0;
    return p;
  endfunction

  function automatic particle_t make_particle(bit kick, int v, int de, bit alive, bit last);
    particle_t p;
    p.kick = kick; p.x = v; p.px = v; p.y = -v; p.py = v; p.z = v; p.de = de;
    p.alive = alive; p.last = last;
    return p;
  endfunction

  task automatic test_field_extremes();
    load_lattice(ONE / 2, ONE, ONE / 8, ONE / 4, 256);
    for (int cmd = 0; cmd < 2; cmd++) begin
      send_particle(make_particle(cmd, 32'sh7fffffff, 32'sh7fffffff, 1, 0));
      send_particle(make_particle(cmd, 32'sh80000000, 32'sh80000000, 1, 1));
      send_particle(make_particle(cmd, 0, 0, 1, 0));
      send_particle(make_particle(cmd, 32'sh0100_0000, -32'sh0080_0000, 1, 1));
    end
  endtask

  task automatic test_dead_particles();
    send_particle(make_particle(1, 32'sh0123_4567, 32'sh0010_0000, 0, 1));
    send_particle(make_particle(1, -32'sh0200_0000, 0, 0, 0));
    send_particle(make_particle(0, 32'sh0123_4567, 32'sh0010_0000, 0, 0));
  endtask

  task automatic test_zero_divisor();
    load_lattice(ONE, ONE, ONE, -ONE, 40'hff_ffff_ffff);
    send_particle(make_particle(0, 32'sh0100_0000, -32'sh0100_0000, 1, 0));
    send_particle(make_particle(0, -32'sh0100_0000, -32'sh0100_0000, 0, 1));
    send_particle(make_particle(0, 32'sh0001_0000, -32'sh00ff_ffff, 1, 0));
    send_particle(make_particle(1, 32'sh0100_0000, 0, 1, 0));
    send_particle(make_particle(1, 0, 0, 1, 1));
  endtask

  task automatic test_register_extremes();
    load_lattice(QHI, 33554431, QHI, QHI, 0);
    for (int i = 0; i < 12; i++) send_particle(rand_particle());
    load_lattice(QLO, 0, QLO, QLO, 40'hff_ffff_ffff);
    for (int i = 0; i < 12; i++) send_particle(rand_particle());
  endtask

  task automatic test_random_stream(int idle, int stall, int count);
    load_lattice(rand_coord(), $urandom_range(ONE), rand_coord() / 8, rand_coord(),
                 {$urandom_range(255), $urandom});
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) send_particle(rand_particle());
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    in_ch.valid = 0; in_ch.command = 0; in_ch.pos_x = 0; in_ch.mom_x = 0;
    in_ch.pos_y = 0; in_ch.mom_y = 0; in_ch.pos_z = 0; in_ch.energy_offset = 0;
    in_ch.alive = 0; in_ch.last_in_pass = 0;
    out_ch.ready = 0;
    len_q = 0; gam_q = ONE; coeff_q = 0; kick_q = 0; width_q = 256;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // defaults straight out of reset
    send_particle(make_particle(0, 32'sh0100_0000, 32'sh0100_0000, 1, 0));
    send_particle(make_particle(1, 32'sh0100_0000, 0, 1, 1));
    test_field_extremes();
    test_dead_particles();
    test_zero_divisor();
    test_register_extremes();
    test_random_stream(0, 0, 100);
    test_random_stream(57, 0, 100);
    test_random_stream(0, 57, 100);
    test_random_stream(32, 32, 100);
    drain_pipe();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
